/* rtl/rbc_pkg.sv */
// Shared types, codes and widths of the retry backoff controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package rbc_pkg;

    // Default sizes, handed to the top level parameters
    localparam int DELAY_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF = 8;

    // Fixed field widths
    localparam int KIND_W     = 2;
    localparam int LIMIT_W    = 8;
    localparam int INIT_W     = 16;
    localparam int CEIL_W     = 24;
    localparam int GROWTH_W   = 12;
    localparam int NUMBER_W   = 8;
    localparam int WAIT_W     = 24;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Event codes
    localparam logic [KIND_W-1:0] EV_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] EV_START   = 2'd1;
    localparam logic [KIND_W-1:0] EV_CANCEL  = 2'd2;
    localparam logic [KIND_W-1:0] EV_OUTCOME = 2'd3;

    // Report codes
    localparam logic [KIND_W-1:0] RPT_BEGUN       = 2'd0;
    localparam logic [KIND_W-1:0] RPT_RECONNECTED = 2'd1;
    localparam logic [KIND_W-1:0] RPT_GAVE_UP     = 2'd2;
    localparam logic [KIND_W-1:0] RPT_REFUSED     = 2'd3;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_INACTIVE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAITING    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ATTEMPTING = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SUCCEEDED  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FAILED     = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_CEILING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GROWTH_FACTOR = 3'd4;

    typedef struct packed {
        logic                enabled;
        logic [LIMIT_W-1:0]  attempt_limit;
        logic [INIT_W-1:0]   initial_delay;
        logic [CEIL_W-1:0]   delay_ceiling;
        logic [GROWTH_W-1:0] growth_factor;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]   report_kind;
        logic [NUMBER_W-1:0] attempt_number;
        logic [LIMIT_W-1:0]  attempt_cap;
        logic [WAIT_W-1:0]   wait_ticks;
        logic [PHASE_W-1:0]  phase_now;
    } report_t;

endpackage

`default_nettype wire

/* rtl/rbc_cfg.sv */
// Configuration register file of the retry backoff controller.
// Depends on rbc_pkg.
`default_nettype none

module rbc_cfg
    import rbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled       <= 1'b1;
            cfg_reg.attempt_limit <= 8'd5;
            cfg_reg.initial_delay <= 16'd1000;
            cfg_reg.delay_ceiling <= 24'd30000;
            cfg_reg.growth_factor <= 12'd512;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ENABLED:       cfg_reg.enabled       <= cfg_data[0];
                REG_ATTEMPT_LIMIT: cfg_reg.attempt_limit <= cfg_data[LIMIT_W-1:0];
                REG_INITIAL_DELAY: cfg_reg.initial_delay <= cfg_data[INIT_W-1:0];
                REG_DELAY_CEILING: cfg_reg.delay_ceiling <= cfg_data[CEIL_W-1:0];
                REG_GROWTH_FACTOR: cfg_reg.growth_factor <= cfg_data[GROWTH_W-1:0];
                default:           ; // drop writes to unmapped indexes
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/rbc_core.sv */
// Retry state registers and the combinational step logic (backoff multiply and clamp).
// Depends on rbc_pkg.
`default_nettype none

module rbc_core
    import rbc_pkg::*;
#(
    parameter int DELAY_BITS = DELAY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [KIND_W-1:0] event_kind,
    input  wire logic              session_valid,
    input  wire logic              attempt_ok,
    input  wire cfg_t              cfg,
    output logic                   emit,
    output report_t                report
);

    localparam int PROD_W = DELAY_BITS + GROWTH_W;

    logic [PHASE_W-1:0]    phase_reg,  phase_next;
    logic [COUNT_BITS-1:0] count_reg,  count_next;
    logic [DELAY_BITS-1:0] delay_reg,  delay_next;
    logic [DELAY_BITS-1:0] remain_reg, remain_next;

    logic                  running;
    logic [PROD_W-1:0]     product;
    logic [PROD_W-1:0]     scaled;
    logic [PROD_W-1:0]     ceiling_w;
    logic [PROD_W-1:0]     bounded;
    logic [DELAY_BITS-1:0] grown_delay;
    logic [15:0]           count_w;
    logic [31:0]           delay_w;
    logic [KIND_W-1:0]     kind_sel;
    logic                  at_limit;

    assign running = (phase_reg == PH_WAITING) || (phase_reg == PH_ATTEMPTING);
    assign count_w = 16'(count_reg);
    assign at_limit = count_w >= 16'(cfg.attempt_limit);

    // delay * growth / 256, clipped to the ceiling, then to the register range
    always_comb
    begin
        product   = PROD_W'(delay_reg) * PROD_W'(cfg.growth_factor);
        scaled    = product >> 8;
        ceiling_w = PROD_W'(cfg.delay_ceiling);
        bounded   = (scaled > ceiling_w) ? ceiling_w : scaled;
        if ((bounded >> DELAY_BITS) != '0)
            grown_delay = '1;
        else
            grown_delay = bounded[DELAY_BITS-1:0];
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        delay_next  = delay_reg;
        remain_next = remain_reg;
        emit        = 1'b0;
        kind_sel    = RPT_BEGUN;

        unique case (event_kind)
            EV_TICK:
            begin
                if (phase_reg == PH_WAITING)
                begin
                    if (remain_reg > DELAY_BITS'(1))
                        remain_next = remain_reg - DELAY_BITS'(1);
                    else
                    begin
                        remain_next = '0;
                        if (count_reg != '1)
                            count_next = count_reg + COUNT_BITS'(1);
                        phase_next = PH_ATTEMPTING;
                        emit       = 1'b1;
                        kind_sel   = RPT_BEGUN;
                    end
                end
            end
            EV_START:
            begin
                priority if (!cfg.enabled)
                begin
                    emit     = 1'b1;
                    kind_sel = RPT_REFUSED;
                end
                else if (running)
                begin
                    // already in a run: hold everything
                end
                else if (!session_valid)
                begin
                    emit     = 1'b1;
                    kind_sel = RPT_REFUSED;
                end
                else
                begin
                    count_next  = '0;
                    delay_next  = DELAY_BITS'(cfg.initial_delay);
                    remain_next = '0;
                    phase_next  = PH_WAITING;
                end
            end
            EV_CANCEL:
            begin
                if (running)
                    phase_next = PH_INACTIVE;
            end
            EV_OUTCOME:
            begin
                if (phase_reg == PH_ATTEMPTING)
                begin
                    priority if (attempt_ok)
                    begin
                        phase_next = PH_SUCCEEDED;
                        emit       = 1'b1;
                        kind_sel   = RPT_RECONNECTED;
                    end
                    else if (at_limit)
                    begin
                        phase_next = PH_FAILED;
                        emit       = 1'b1;
                        kind_sel   = RPT_GAVE_UP;
                    end
                    else
                    begin
                        delay_next  = grown_delay;
                        remain_next = grown_delay;
                        phase_next  = PH_WAITING;
                    end
                end
            end
            default: ;
        endcase
    end

    // Report fields show the state after the event
    always_comb
    begin
        delay_w               = 32'(delay_next);
        report.report_kind    = kind_sel;
        report.attempt_number = 16'(count_next) >> 0 == 16'(count_next)
                                ? NUMBER_W'(16'(count_next)) : '0;
        report.attempt_cap    = cfg.attempt_limit;
        report.wait_ticks     = delay_w[WAIT_W-1:0];
        report.phase_now      = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_INACTIVE;
            count_reg  <= '0;
            delay_reg  <= '0;
            remain_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            delay_reg  <= delay_next;
            remain_reg <= remain_next;
        end
    end

`ifndef SYNTHESIS
    // A begun report always leaves the controller attempting
    assert property (@(posedge clk) disable iff (!rst_n)
        step && emit && (report.report_kind == RPT_BEGUN) |=> phase_reg == PH_ATTEMPTING)
        else $error("attempt begun without entering attempting phase");

    // Only a start may lower the attempt count
    assert property (@(posedge clk) disable iff (!rst_n)
        step && (event_kind != EV_START) |=> count_reg >= $past(count_reg))
        else $error("attempt count fell outside a start");

    // An attempt in progress has been counted
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ATTEMPTING |-> count_reg != '0)
        else $error("attempting with zero attempt count");

    // State changes only on a step
    assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(delay_reg))
        else $error("state moved without an accepted word");
`endif

endmodule

`default_nettype wire

/* rtl/retry_backoff_controller.sv */
// Top level of the retry backoff controller: input and result registers around the step core.
// Depends on rbc_pkg, rbc_cfg and rbc_core.
//
//  channel | direction | handshake             | contents
//  --------+-----------+-----------------------+---------------------------------------------
//  s_      | in        | s_tvalid / s_tready   | event word: tuser kind, tdata session/outcome
//  m_      | out       | m_tvalid / m_tready   | report word: tuser report kind, tdata fields
//  cfg_    | in        | cfg_valid / cfg_ready | register index and write data
//
// The step core handles each event word combinationally; a new word may enter every cycle
// while the report side does not stall. A report-raising word passes through the input
// register, then the result register; the backoff multiply and clamp sit between the two.
// Reset clears the run state and loads the register defaults; the port is ready at once.
// A stalled report holds the result register and stops the step core for every word;
// the input register takes at most one more word and holds it, dropping s_tready until
// the sink drains the report.
`default_nettype none

module retry_backoff_controller
    import rbc_pkg::*;
#(
    parameter int DELAY_BITS = DELAY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [0] session_valid, [1] attempt_ok, [7:2] zero
    input  wire logic [KIND_W-1:0]     s_tuser,   // [1:0] event_kind

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,   // [7:0] attempt_number, [15:8] attempt_cap,
                                                  // [39:16] wait_ticks, [42:40] phase_now,
                                                  // [47:43] zero
    output logic [KIND_W-1:0]          m_tuser,   // [1:0] report_kind

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Input register
    logic              in_valid_reg, in_valid_next;
    logic [KIND_W-1:0] in_kind_reg;
    logic              in_session_reg;
    logic              in_ok_reg;

    // Result register
    logic              out_valid_reg, out_valid_next;
    report_t           out_report_reg;

    logic              step;
    logic              emit;
    report_t           report;
    cfg_t              cfg;

    // Advance a held word when the result register is free or draining this cycle
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    assign in_valid_next  = s_tvalid ? 1'b1 : (in_valid_reg && !step);
    assign out_valid_next = (step && emit) ? 1'b1 : (out_valid_reg && !m_tready);

    rbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rbc_core #(
        .DELAY_BITS (DELAY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .event_kind    (in_kind_reg),
        .session_valid (in_session_reg),
        .attempt_ok    (in_ok_reg),
        .cfg           (cfg),
        .emit          (emit),
        .report        (report)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture a new event word whenever the input side is ready
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg    <= s_tuser;
            in_session_reg <= s_tdata[0];
            in_ok_reg      <= s_tdata[1];
        end
    end

    // Load the report word; hold it while the sink stalls
    always_ff @(posedge clk)
    begin
        if (step && emit)
            out_report_reg <= report;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_report_reg.report_kind;
    assign m_tdata  = {5'd0,
                       out_report_reg.phase_now,
                       out_report_reg.wait_ticks,
                       out_report_reg.attempt_cap,
                       out_report_reg.attempt_number};

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for retry_backoff_controller: event words in, report words out.
// Depends on rbc_pkg and the RTL; carries its own model of the backoff controller.
`default_nettype none

module tb;
    import rbc_pkg::*;

    localparam int      WATCHDOG_LIMIT = 4000;
    localparam int      SETTLE_CYCLES  = 6;
    localparam int      RANDOM_ITEMS   = 1000;
    localparam int      HOLD_CYCLES    = 300;
    localparam longint  DELAY_MAX      = (64'd1 << DELAY_BITS_DEF) - 1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = EV_TICK;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [47:0]           m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ENABLED;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    retry_backoff_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [0] session_valid, [1] attempt_ok, [7:2] zero
        .s_tuser   (s_tuser),    // [1:0] event_kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] attempt_number, [15:8] attempt_cap,
                                 // [39:16] wait_ticks, [42:40] phase_now
        .m_tuser   (m_tuser),    // [1:0] report_kind
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // ------------------------------------------------------------------
    // Mirror of the controller: register copies and run state
    // ------------------------------------------------------------------
    logic                       cfg_en;
    logic [LIMIT_W-1:0]         cfg_limit;
    logic [INIT_W-1:0]          cfg_init;
    logic [CEIL_W-1:0]          cfg_ceil;
    logic [GROWTH_W-1:0]        cfg_growth;

    logic [PHASE_W-1:0]         run_phase;
    logic [COUNT_BITS_DEF-1:0]  tries;
    logic [WAIT_W-1:0]          backoff;
    logic [WAIT_W-1:0]          ticks_left;

    report_t pending_reports[$];   // reports owed by the block, oldest first
    int      mismatches      = 0;
    int      effective_items = 0;  // words that moved the state or raised a report
    int      hold_off        = 0;  // long receiver stall requested by a test
    bit      sender_calm     = 1'b0;
    bit      receiver_calm   = 1'b0;

    task automatic reset_mirror();
        cfg_en     = 1'b1;
        cfg_limit  = 8'd5;
        cfg_init   = 16'd1000;
        cfg_ceil   = 24'd30000;
        cfg_growth = 12'd512;
        run_phase  = PH_INACTIVE;
        tries      = '0;
        backoff    = '0;
        ticks_left = '0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_ENABLED:       cfg_en     = value[0];
            REG_ATTEMPT_LIMIT: cfg_limit  = value[LIMIT_W-1:0];
            REG_INITIAL_DELAY: cfg_init   = value[INIT_W-1:0];
            REG_DELAY_CEILING: cfg_ceil   = value[CEIL_W-1:0];
            REG_GROWTH_FACTOR: cfg_growth = value[GROWTH_W-1:0];
            default:           ;
        endcase
    endtask

    // Advance the mirror by one event; return one when a report is due.
    function automatic bit advance_controller(input logic [KIND_W-1:0] kind,
                                              input logic sess, input logic ok,
                                              output report_t rpt);
        logic [47:0]       grown;
        bit                running;
        bit                raise;
        logic [KIND_W-1:0] code;
        running = (run_phase == PH_WAITING) || (run_phase == PH_ATTEMPTING);
        raise   = 1'b0;
        code    = RPT_BEGUN;
        case (kind)
            EV_TICK:
            begin
                if (run_phase == PH_WAITING)
                begin
                    if (ticks_left > 1)
                        ticks_left = ticks_left - 1'b1;
                    else
                    begin
                        // wait over: count the attempt, saturating
                        ticks_left = '0;
                        if (tries != '1)
                            tries = tries + 1'b1;
                        run_phase = PH_ATTEMPTING;
                        raise     = 1'b1;
                        code      = RPT_BEGUN;
                    end
                end
            end
            EV_START:
            begin
                // disabled refuses in every phase; a running controller ignores
                if (!cfg_en)
                begin
                    raise = 1'b1;
                    code  = RPT_REFUSED;
                end
                else if (!running)
                begin
                    if (!sess)
                    begin
                        raise = 1'b1;
                        code  = RPT_REFUSED;
                    end
                    else
                    begin
                        tries      = '0;
                        backoff    = WAIT_W'(cfg_init);
                        ticks_left = '0;
                        run_phase  = PH_WAITING;
                    end
                end
            end
            EV_CANCEL:
            begin
                if (running)
                    run_phase = PH_INACTIVE;
            end
            default:
            begin
                if (run_phase == PH_ATTEMPTING)
                begin
                    raise = 1'b1;
                    if (ok)
                    begin
                        run_phase = PH_SUCCEEDED;
                        code      = RPT_RECONNECTED;
                    end
                    else if (tries >= cfg_limit)
                    begin
                        run_phase = PH_FAILED;
                        code      = RPT_GAVE_UP;
                    end
                    else
                    begin
                        // grow the delay in Q4.8, clamp to the ceiling and the width
                        raise = 1'b0;
                        grown = 48'(backoff);
                        grown = (grown * cfg_growth) >> 8;
                        if (grown > cfg_ceil)
                            grown = 48'(cfg_ceil);
                        if (grown > DELAY_MAX)
                            grown = 48'(DELAY_MAX);
                        backoff    = grown[WAIT_W-1:0];
                        ticks_left = backoff;
                        run_phase  = PH_WAITING;
                    end
                end
            end
        endcase
        rpt.report_kind    = code;
        rpt.attempt_number = tries;
        rpt.attempt_cap    = cfg_limit;
        rpt.wait_ticks     = backoff;
        rpt.phase_now      = run_phase;
        return raise;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic int idle_cycles(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // Offer one event word, hold it until taken, then predict its report.
    task automatic send_event(input logic [KIND_W-1:0] kind, input logic sess,
                              input logic ok);
        int                gap;
        report_t           rpt;
        logic [58:0]       snapshot;
        bit                raise;
        gap = idle_cycles(sender_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, ok, sess};
        do @(posedge clk); while (!s_tready);
        snapshot = {run_phase, tries, backoff, ticks_left};
        raise    = advance_controller(kind, sess, ok, rpt);
        if (raise)
            pending_reports.push_back(rpt);
        if (raise || snapshot != {run_phase, tries, backoff, ticks_left})
            effective_items++;
    endtask

    task automatic send_noise();
        send_event(KIND_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endtask

    // Drop valid, wait for every owed report, then let in-flight words clear.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, value);
    endtask

    // Sometimes fill the bits above the register width with noise.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                       input int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = (width >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << width) - 1'b1);
        if ($urandom_range(0, 3) == 0)
            return (value & keep) | (CFG_DATA_W'($urandom) & ~keep);
        return value & keep;
    endfunction

    task automatic configure(input logic en, input logic [LIMIT_W-1:0] lim,
                             input logic [INIT_W-1:0] init, input logic [CEIL_W-1:0] ceil,
                             input logic [GROWTH_W-1:0] growth);
        write_reg(REG_ENABLED,       with_junk(CFG_DATA_W'(en), 1));
        write_reg(REG_ATTEMPT_LIMIT, with_junk(CFG_DATA_W'(lim), LIMIT_W));
        write_reg(REG_INITIAL_DELAY, with_junk(CFG_DATA_W'(init), INIT_W));
        write_reg(REG_DELAY_CEILING, with_junk(ceil, CEIL_W));
        write_reg(REG_GROWTH_FACTOR, with_junk(CFG_DATA_W'(growth), GROWTH_W));
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus a long hold when a test asks
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off > 0)
            begin
                stall    = hold_off;
                hold_off = 0;
            end
            else
                stall = idle_cycles(receiver_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid && hold_off == 0);
        end
    end

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        $display("tb: %s mismatch, expected %0h got %0h at %0t", what, want, got, $time);
    endtask

    // Compare each taken report word with the oldest one owed.
    always @(posedge clk)
    begin : report_checker
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
                note_mismatch("unexpected report word", longint'(0), longint'(m_tuser));
            else
            begin
                want = pending_reports.pop_front();
                if (m_tuser != want.report_kind)
                    note_mismatch("report_kind", longint'(want.report_kind),
                                  longint'(m_tuser));
                if (m_tdata[7:0] != want.attempt_number)
                    note_mismatch("attempt_number", longint'(want.attempt_number),
                                  longint'(m_tdata[7:0]));
                if (m_tdata[15:8] != want.attempt_cap)
                    note_mismatch("attempt_cap", longint'(want.attempt_cap),
                                  longint'(m_tdata[15:8]));
                if (m_tdata[39:16] != want.wait_ticks)
                    note_mismatch("wait_ticks", longint'(want.wait_ticks),
                                  longint'(m_tdata[39:16]));
                if (m_tdata[42:40] != want.phase_now)
                    note_mismatch("phase_now", longint'(want.phase_now),
                                  longint'(m_tdata[42:40]));
            end
        end
    end

    // Abort when no word moves on any channel for too long.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Defaults straight out of reset: ignored events, refusal, one full run.
    task automatic test_reset_defaults();
        send_event(EV_TICK, 1'b1, 1'b1);
        send_event(EV_OUTCOME, 1'b1, 1'b1);
        send_event(EV_CANCEL, 1'b1, 1'b1);
        send_event(EV_START, 1'b0, 1'b1);       // no session: refused
        send_event(EV_START, 1'b1, 1'b0);
        send_event(EV_START, 1'b0, 1'b0);       // already running: ignored
        send_event(EV_TICK, 1'b0, 1'b0);        // first attempt on the next tick
        send_event(EV_OUTCOME, 1'b0, 1'b1);     // reconnected
        send_event(EV_START, 1'b1, 1'b1);       // restart from succeeded
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_OUTCOME, 1'b1, 1'b0);     // fail: delay doubles
        send_event(EV_OUTCOME, 1'b1, 1'b1);     // outcome while waiting: ignored
        send_event(EV_TICK, 1'b1, 1'b0);
        send_event(EV_CANCEL, 1'b0, 1'b0);
        send_event(EV_CANCEL, 1'b0, 1'b0);      // cancel while inactive: nothing
    endtask

    // Disabled refusal, zero attempt limit, delay of one, disable mid-wait.
    task automatic test_special_cases();
        write_reg(REG_ENABLED, '0);
        send_event(EV_START, 1'b1, 1'b1);       // refused, state echoed untouched
        configure(1'b1, 8'd0, 16'd1, 24'd30000, 12'd256);
        send_event(EV_START, 1'b1, 1'b0);
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_OUTCOME, 1'b0, 1'b0);     // limit zero: gives up at once
        send_event(EV_OUTCOME, 1'b0, 1'b0);     // ignored in failed
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_CANCEL, 1'b0, 1'b0);
        write_reg(REG_ATTEMPT_LIMIT, 24'd3);
        send_event(EV_START, 1'b1, 1'b0);
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_OUTCOME, 1'b0, 1'b0);     // delay one: next tick begins
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_OUTCOME, 1'b0, 1'b0);
        write_reg(REG_ENABLED, '0);
        send_event(EV_START, 1'b0, 1'b0);       // refused while waiting
        write_reg(REG_ENABLED, 24'd1);
        send_event(EV_START, 1'b1, 1'b1);       // ignored while waiting
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_OUTCOME, 1'b0, 1'b0);     // count reaches the limit
    endtask

    // Register extremes; refusals expose delays too long to wait out.
    task automatic test_register_extremes();
        int i;
        configure(1'b1, 8'd255, 16'hFFFF, 24'hFFFFFF, 12'hFFF);
        send_event(EV_START, 1'b1, 1'b0);
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_OUTCOME, 1'b0, 1'b0);
        write_reg(REG_ENABLED, '0);
        send_event(EV_START, 1'b1, 1'b0);
        write_reg(REG_ENABLED, 24'd1);
        send_event(EV_CANCEL, 1'b0, 1'b0);
        // clamp to a small ceiling, then wait it out
        configure(1'b1, 8'd2, 16'hFFFF, 24'd5, 12'hFFF);
        send_event(EV_START, 1'b1, 1'b0);
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_OUTCOME, 1'b0, 1'b0);
        while (run_phase == PH_WAITING)
            send_event(EV_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_event(EV_OUTCOME, 1'b0, 1'b0);
        // zero growth collapses the delay; just below one shrinks it
        configure(1'b1, 8'd4, 16'd200, 24'hFFFFFF, 12'd0);
        send_event(EV_START, 1'b1, 1'b0);
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_OUTCOME, 1'b0, 1'b0);
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_OUTCOME, 1'b0, 1'b1);
        configure(1'b1, 8'd3, 16'd1000, 24'hFFFFFF, 12'd255);
        send_event(EV_START, 1'b1, 1'b0);
        send_event(EV_TICK, 1'b0, 1'b0);
        send_event(EV_OUTCOME, 1'b0, 1'b0);
        write_reg(REG_ENABLED, '0);
        send_event(EV_START, 1'b1, 1'b1);
        write_reg(REG_ENABLED, 24'd1);
        send_event(EV_CANCEL, 1'b0, 1'b0);
        // unused indexes must leave every register alone
        for (i = REG_GROWTH_FACTOR + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        send_event(EV_START, 1'b0, 1'b0);
    endtask

    // Run the attempt count right up to the widest limit with zero delay.
    task automatic test_long_run();
        configure(1'b1, 8'd255, 16'd0, 24'd0, GROWTH_W'($urandom_range(0, 4095)));
        send_event(EV_START, 1'b1, 1'($urandom_range(0, 1)));
        while (run_phase == PH_WAITING || run_phase == PH_ATTEMPTING)
        begin
            if (run_phase == PH_WAITING)
                send_event(EV_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                send_event(EV_OUTCOME, 1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    // Hold the receiver off while the sender keeps offering report-raising words.
    task automatic test_backpressure();
        configure(1'b1, 8'd255, 16'd0, 24'd0, 12'd512);
        sender_calm = 1'b1;
        hold_off    = HOLD_CYCLES;
        send_event(EV_START, 1'b1, 1'b0);
        repeat (30)
        begin
            send_event(EV_TICK, 1'b0, 1'b0);
            send_event(EV_OUTCOME, 1'b0, 1'b0);
        end
        send_event(EV_CANCEL, 1'b0, 1'b0);
        sender_calm = 1'b0;
        wait_idle();
    endtask

    // One session: mostly the well-formed path, some noise and early cancels.
    task automatic run_session();
        int pick;
        send_event(EV_START, $urandom_range(0, 5) != 0, 1'($urandom_range(0, 1)));
        while (run_phase == PH_WAITING || run_phase == PH_ATTEMPTING)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_noise();
            else if (pick < 8)
                send_event(EV_CANCEL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (run_phase == PH_WAITING)
                send_event(EV_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                send_event(EV_OUTCOME, 1'($urandom_range(0, 1)),
                           $urandom_range(0, 99) < 25);
        end
        if ($urandom_range(0, 3) == 0)
            send_noise();
    endtask

    task automatic test_random();
        int target;
        target = effective_items + RANDOM_ITEMS;
        while (effective_items < target)
        begin
            // mostly short delays; now and then a long first delay or ceiling
            configure($urandom_range(0, 5) != 0,
                      LIMIT_W'($urandom_range(0, 10)),
                      ($urandom_range(0, 7) == 0) ? INIT_W'($urandom_range(0, 65535))
                                                  : INIT_W'($urandom_range(0, 6)),
                      ($urandom_range(0, 7) == 0) ? CEIL_W'($urandom_range(25, 300))
                                                  : CEIL_W'($urandom_range(0, 24)),
                      GROWTH_W'($urandom_range(0, 4095)));
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 10))
                if (effective_items < target)
                    run_session();
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
    endtask

    initial
    begin
        reset_mirror();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_special_cases();
        test_register_extremes();
        test_long_run();
        test_backpressure();
        test_random();
        wait_idle();
        if (pending_reports.size() != 0)
            note_mismatch("reports never delivered", longint'(0),
                          longint'(pending_reports.size()));
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
